// ===== rtl/tvfg_pkg.sv =====
// Shared types, constants and tables of the torus vertex frame generator.
package tvfg_pkg;

  // Field and register widths.
  localparam int IDX_W      = 11;
  localparam int CNT_W      = 11;
  localparam int RAD_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int COMP_W     = 32;
  localparam int KIND_W     = 3;
  localparam int NUM_KINDS  = 5;

  // Angle resolution and texture fraction bits.
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_W     = 16;
  localparam int TEX_W      = IDX_W + FRAC_W;

  // Angle unit: one divider stage per quotient bit, one stage per rotation.
  localparam int DIV_STAGES   = TEX_W;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam int UNIT_W       = 18;
  localparam int ANGLE_LAT    = DIV_STAGES + CORDIC_STEPS + 3;

  // Queue between the angle front and the vector back.
  localparam int QDEPTH = 16;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Arctangent of 2^-k in units of 2^-32 turns.
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_POS = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TEX = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAN = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NRM = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BIN = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RINGS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDES = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] ring_index;
    logic [IDX_W-1:0] side_index;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]        vector_kind;
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;
    logic                     degenerate;
    logic                     last_of_vertex;
  } out_item_t;

  // Angles of one vertex as they leave the front.
  typedef struct packed {
    logic [TEX_W-1:0]         tex_u;
    logic [TEX_W-1:0]         tex_v;
    logic signed [UNIT_W-1:0] cos_t;
    logic signed [UNIT_W-1:0] sin_t;
    logic signed [UNIT_W-1:0] cos_p;
    logic signed [UNIT_W-1:0] sin_p;
  } job_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } vec_t;

  // Queue status passed to the back.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/tvfg_angle_unit.sv =====
// Pipelined index-to-angle divider followed by a pipelined sine/cosine rotator.
module tvfg_angle_unit (
  input  logic                              clk,
  input  logic [tvfg_pkg::IDX_W-1:0]        idx,
  input  logic [tvfg_pkg::CNT_W-1:0]        count,
  output logic [tvfg_pkg::TEX_W-1:0]        tex_o,
  output logic signed [tvfg_pkg::UNIT_W-1:0] cos_o,
  output logic signed [tvfg_pkg::UNIT_W-1:0] sin_o
);
  import tvfg_pkg::*;

  logic [CNT_W-1:0] rem_r [DIV_STAGES+1];
  logic [TEX_W-1:0] quo_r [DIV_STAGES+1];
  logic [TEX_W-1:0] dvd_r [DIV_STAGES+1];

  logic signed [CW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] z_r [CORDIC_STEPS+1];
  logic [1:0]           qd_r [CORDIC_STEPS+1];
  logic [TEX_W-1:0]     tx_r [CORDIC_STEPS+1];

  logic [31:0]             p32;
  logic [31:0]             p_sum;
  logic [1:0]              quad;
  logic [31:0]             z32;
  logic signed [CW-1:0]    xr_sum;
  logic signed [CW-1:0]    yr_sum;
  logic signed [19:0]      cx_raw;
  logic signed [19:0]      sy_raw;
  logic signed [UNIT_W-1:0] cx;
  logic signed [UNIT_W-1:0] sy;
  logic [TEX_W-1:0]        tex_r;
  logic signed [UNIT_W-1:0] cos_r;
  logic signed [UNIT_W-1:0] sin_r;

  // Dividend is the index shifted up by the fraction width.
  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    quo_r[0] <= '0;
    dvd_r[0] <= {idx, {FRAC_W{1'b0}}};
  end

  // Restoring division, one quotient bit per stage.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [CNT_W:0] trial;
    assign trial = {rem_r[s], dvd_r[s][TEX_W-1]};
    always_ff @(posedge clk) begin
      if (trial >= {1'b0, count}) begin
        rem_r[s+1] <= CNT_W'(trial - {1'b0, count});
        quo_r[s+1] <= {quo_r[s][TEX_W-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= trial[CNT_W-1:0];
        quo_r[s+1] <= {quo_r[s][TEX_W-2:0], 1'b0};
      end
      dvd_r[s+1] <= dvd_r[s] << 1;
    end
  end

  // Nearest quadrant and residual angle in 2^-32 turns.
  always_comb begin
    p32   = {quo_r[DIV_STAGES][ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    p_sum = p32 + 32'h2000_0000;
    quad  = p_sum[31:30];
    z32   = p32 - {quad, 30'b0};
  end

  always_ff @(posedge clk) begin
    x_r[0]  <= CORDIC_GAIN;
    y_r[0]  <= '0;
    z_r[0]  <= CW'($signed(z32));
    qd_r[0] <= quad;
    tx_r[0] <= quo_r[DIV_STAGES];
  end

  // Rotation stages, fixed shift per stage.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;
    assign at = CW'(ATAN_TURNS[k]);
    always_ff @(posedge clk) begin
      if (!z_r[k][CW-1]) begin
        x_r[k+1] <= x_r[k] - dx;
        y_r[k+1] <= y_r[k] + dy;
        z_r[k+1] <= z_r[k] - at;
      end else begin
        x_r[k+1] <= x_r[k] + dx;
        y_r[k+1] <= y_r[k] - dy;
        z_r[k+1] <= z_r[k] + at;
      end
      qd_r[k+1] <= qd_r[k];
      tx_r[k+1] <= tx_r[k];
    end
  end

  // Round to signed Q2.16, clamp to the unit range.
  always_comb begin
    xr_sum = x_r[CORDIC_STEPS] + CW'(8192);
    yr_sum = y_r[CORDIC_STEPS] + CW'(8192);
    cx_raw = $signed(xr_sum[33:14]);
    sy_raw = $signed(yr_sum[33:14]);
    if (cx_raw > 20'sd65536) begin
      cx = 18'sd65536;
    end else if (cx_raw < -20'sd65536) begin
      cx = -18'sd65536;
    end else begin
      cx = cx_raw[UNIT_W-1:0];
    end
    if (sy_raw > 20'sd65536) begin
      sy = 18'sd65536;
    end else if (sy_raw < -20'sd65536) begin
      sy = -18'sd65536;
    end else begin
      sy = sy_raw[UNIT_W-1:0];
    end
  end

  // Fold the quadrant back in.
  always_ff @(posedge clk) begin
    tex_r <= tx_r[CORDIC_STEPS];
    unique case (qd_r[CORDIC_STEPS])
      2'd0: begin
        cos_r <= cx;
        sin_r <= sy;
      end
      2'd1: begin
        cos_r <= -sy;
        sin_r <= cx;
      end
      2'd2: begin
        cos_r <= -cx;
        sin_r <= -sy;
      end
      default: begin
        cos_r <= sy;
        sin_r <= -cx;
      end
    endcase
  end

  assign tex_o = tex_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ===== rtl/tvfg_front.sv =====
// Request intake, credit control and the two angle units.
module tvfg_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  tvfg_pkg::in_item_t       in_data,
  input  logic [tvfg_pkg::CNT_W-1:0] rings,
  input  logic [tvfg_pkg::CNT_W-1:0] sides,
  input  logic                     q_pop,
  output logic                     q_push,
  output tvfg_pkg::job_t           q_wdata
);
  import tvfg_pkg::*;

  logic [QCNT_W-1:0] credit_r;
  logic [QCNT_W-1:0] credit_nxt;
  logic              vld_r [ANGLE_LAT];
  logic              accept;

  // A request enters only if the queue is sure to have room for it.
  assign in_stall = (credit_r == QCNT_W'(QDEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    credit_nxt = credit_r;
    if (accept && !q_pop) begin
      credit_nxt = credit_r + 1'b1;
    end else if (!accept && q_pop) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  // Valid bits follow the fixed latency of the angle units.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ANGLE_LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int k = 1; k < ANGLE_LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign q_push = vld_r[ANGLE_LAT-1];

  // Ring angle theta and side angle phi.
  tvfg_angle_unit u_theta (
    .clk   (clk),
    .idx   (in_data.ring_index),
    .count (rings),
    .tex_o (q_wdata.tex_v),
    .cos_o (q_wdata.cos_t),
    .sin_o (q_wdata.sin_t)
  );

  tvfg_angle_unit u_phi (
    .clk   (clk),
    .idx   (in_data.side_index),
    .count (sides),
    .tex_o (q_wdata.tex_u),
    .cos_o (q_wdata.cos_p),
    .sin_o (q_wdata.sin_p)
  );

endmodule

// ===== rtl/tvfg_queue.sv =====
// Small FIFO of angle sets between the front and the back.
module tvfg_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tvfg_pkg::job_t       wdata,
  input  logic                 pop,
  output tvfg_pkg::job_t       rdata,
  output tvfg_pkg::q_status_t  stat
);
  import tvfg_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QCNT_W-1:0] cnt_r;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign rdata      = mem_r[rd_r];
  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));

endmodule

// ===== rtl/tvfg_back.sv =====
// Vector arithmetic on one angle set and the five-result output sequencer.
module tvfg_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tvfg_pkg::RAD_W-1:0] minor_radius,
  input  logic [tvfg_pkg::RAD_W-1:0] major_radius,
  input  tvfg_pkg::q_status_t       q_stat,
  input  tvfg_pkg::job_t            q_rdata,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tvfg_pkg::out_item_t       out_data
);
  import tvfg_pkg::*;

  // Stage A: first products.
  logic                     va_r;
  logic signed [34:0]       a_rc_r;
  logic signed [34:0]       a_rs_r;
  logic signed [35:0]       a_cc_r;
  logic signed [35:0]       a_sc_r;
  logic signed [UNIT_W-1:0] a_ct_r;
  logic signed [UNIT_W-1:0] a_st_r;
  logic signed [UNIT_W-1:0] a_sp_r;
  logic [TEX_W-1:0]         a_tu_r;
  logic [TEX_W-1:0]         a_tv_r;

  // Stage B: distance, normal, tangent.
  logic                     vb_r;
  logic signed [26:0]       b_dist_r;
  logic signed [UNIT_W-1:0] b_tx_r;
  logic signed [UNIT_W-1:0] b_ty_r;
  logic signed [UNIT_W-1:0] b_nx_r;
  logic signed [UNIT_W-1:0] b_ny_r;
  logic signed [UNIT_W-1:0] b_nz_r;
  logic signed [26:0]       b_pz_r;
  logic signed [UNIT_W-1:0] b_ct_r;
  logic signed [UNIT_W-1:0] b_st_r;
  logic [TEX_W-1:0]         b_tu_r;
  logic [TEX_W-1:0]         b_tv_r;
  logic                     b_dg_r;

  // Stage C: second products.
  logic                     vc_r;
  logic signed [44:0]       c_pcd_r;
  logic signed [44:0]       c_psd_r;
  logic signed [35:0]       c_nzty_r;
  logic signed [35:0]       c_nztx_r;
  logic signed [35:0]       c_nxty_r;
  logic signed [35:0]       c_nytx_r;
  logic signed [UNIT_W-1:0] c_tx_r;
  logic signed [UNIT_W-1:0] c_ty_r;
  logic signed [UNIT_W-1:0] c_nx_r;
  logic signed [UNIT_W-1:0] c_ny_r;
  logic signed [UNIT_W-1:0] c_nz_r;
  logic signed [26:0]       c_pz_r;
  logic [TEX_W-1:0]         c_tu_r;
  logic [TEX_W-1:0]         c_tv_r;
  logic                     c_dg_r;

  // Output buffer holding the five vectors of one vertex.
  logic              vo_r;
  vec_t              vec_r [NUM_KINDS];
  logic [KIND_W-1:0] kind_r;
  logic              dg_r;

  logic done;
  logic buf_free;
  logic c_adv;
  logic c_free;
  logic b_adv;
  logic b_free;
  logic a_adv;
  logic a_free;

  logic signed [16:0] r_s;
  logic signed [34:0] rc_sum;
  logic signed [34:0] rs_sum;
  logic signed [35:0] cc_sum;
  logic signed [35:0] sc_sum;
  logic signed [26:0] dist_val;
  logic signed [44:0] pcd_sum;
  logic signed [44:0] psd_sum;
  logic signed [35:0] bx_sum;
  logic signed [35:0] by_sum;
  logic signed [36:0] bz_diff;
  logic signed [36:0] bz_sum;
  vec_t               v_pos;
  vec_t               v_tex;
  vec_t               v_tan;
  vec_t               v_nrm;
  vec_t               v_bin;

  // Stage advance: each stage moves when the one after it has room.
  assign done     = vo_r && !out_stall && (kind_r == KIND_BIN);
  assign buf_free = !vo_r || done;
  assign c_adv    = vc_r && buf_free;
  assign c_free   = !vc_r || c_adv;
  assign b_adv    = vb_r && c_free;
  assign b_free   = !vb_r || b_adv;
  assign a_adv    = va_r && b_free;
  assign a_free   = !va_r || a_adv;
  assign q_pop    = q_stat.valid && a_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (a_free) begin
        va_r <= q_stat.valid;
      end
      if (b_free) begin
        vb_r <= va_r;
      end
      if (c_free) begin
        vc_r <= vb_r;
      end
    end
  end

  // Stage A products.
  assign r_s = $signed({1'b0, minor_radius});

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_rc_r <= r_s * $signed(q_rdata.cos_p);
      a_rs_r <= r_s * $signed(q_rdata.sin_p);
      a_cc_r <= $signed(q_rdata.cos_t) * $signed(q_rdata.cos_p);
      a_sc_r <= $signed(q_rdata.sin_t) * $signed(q_rdata.cos_p);
      a_ct_r <= q_rdata.cos_t;
      a_st_r <= q_rdata.sin_t;
      a_sp_r <= q_rdata.sin_p;
      a_tu_r <= q_rdata.tex_u;
      a_tv_r <= q_rdata.tex_v;
    end
  end

  // Stage B: round products, form distance and sign-selected tangent.
  always_comb begin
    rc_sum   = a_rc_r + 35'sd128;
    rs_sum   = a_rs_r + 35'sd128;
    cc_sum   = a_cc_r + 36'sd32768;
    sc_sum   = -a_sc_r + 36'sd32768;
    dist_val = $signed({3'b0, major_radius, 8'b0}) + $signed(rc_sum[34:8]);
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_dist_r <= dist_val;
      if (dist_val > 27'sd0) begin
        b_tx_r <= -a_st_r;
        b_ty_r <= -a_ct_r;
      end else if (dist_val < 27'sd0) begin
        b_tx_r <= a_st_r;
        b_ty_r <= a_ct_r;
      end else begin
        b_tx_r <= '0;
        b_ty_r <= '0;
      end
      b_nx_r <= cc_sum[33:16];
      b_ny_r <= sc_sum[33:16];
      b_nz_r <= a_sp_r;
      b_pz_r <= rs_sum[34:8];
      b_ct_r <= a_ct_r;
      b_st_r <= a_st_r;
      b_tu_r <= a_tu_r;
      b_tv_r <= a_tv_r;
      b_dg_r <= (dist_val == 27'sd0);
    end
  end

  // Stage C products.
  always_ff @(posedge clk) begin
    if (b_adv) begin
      c_pcd_r  <= b_ct_r * b_dist_r;
      c_psd_r  <= b_st_r * b_dist_r;
      c_nzty_r <= b_nz_r * b_ty_r;
      c_nztx_r <= b_nz_r * b_tx_r;
      c_nxty_r <= b_nx_r * b_ty_r;
      c_nytx_r <= b_ny_r * b_tx_r;
      c_tx_r   <= b_tx_r;
      c_ty_r   <= b_ty_r;
      c_nx_r   <= b_nx_r;
      c_ny_r   <= b_ny_r;
      c_nz_r   <= b_nz_r;
      c_pz_r   <= b_pz_r;
      c_tu_r   <= b_tu_r;
      c_tv_r   <= b_tv_r;
      c_dg_r   <= b_dg_r;
    end
  end

  // Final rounding and assembly of the five vectors.
  always_comb begin
    pcd_sum = c_pcd_r + 45'sd32768;
    psd_sum = -c_psd_r + 45'sd32768;
    bx_sum  = -c_nzty_r + 36'sd32768;
    by_sum  = c_nztx_r + 36'sd32768;
    bz_diff = 37'(c_nxty_r) - 37'(c_nytx_r);
    bz_sum  = bz_diff + 37'sd32768;

    v_pos.x = COMP_W'($signed(pcd_sum[44:16]));
    v_pos.y = COMP_W'($signed(psd_sum[44:16]));
    v_pos.z = COMP_W'(c_pz_r);

    v_tex.x = $signed(COMP_W'(c_tu_r));
    v_tex.y = $signed(COMP_W'(c_tv_r));
    v_tex.z = '0;

    v_tan.x = COMP_W'(c_tx_r);
    v_tan.y = COMP_W'(c_ty_r);
    v_tan.z = '0;

    v_nrm.x = COMP_W'(c_nx_r);
    v_nrm.y = COMP_W'(c_ny_r);
    v_nrm.z = COMP_W'(c_nz_r);

    v_bin.x = COMP_W'($signed(bx_sum[35:16]));
    v_bin.y = COMP_W'($signed(by_sum[35:16]));
    v_bin.z = COMP_W'($signed(bz_sum[36:16]));
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      vec_r[KIND_POS] <= v_pos;
      vec_r[KIND_TEX] <= v_tex;
      vec_r[KIND_TAN] <= v_tan;
      vec_r[KIND_NRM] <= v_nrm;
      vec_r[KIND_BIN] <= v_bin;
      dg_r            <= c_dg_r;
    end
  end

  // Output sequencer: one vector per accepted result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r   <= 1'b0;
      kind_r <= KIND_POS;
    end else if (c_adv) begin
      vo_r   <= 1'b1;
      kind_r <= KIND_POS;
    end else if (done) begin
      vo_r   <= 1'b0;
      kind_r <= KIND_POS;
    end else if (vo_r && !out_stall) begin
      kind_r <= kind_r + 1'b1;
    end
  end

  assign out_valid               = vo_r;
  assign out_data.vector_kind    = kind_r;
  assign out_data.comp_x         = vec_r[kind_r].x;
  assign out_data.comp_y         = vec_r[kind_r].y;
  assign out_data.comp_z         = vec_r[kind_r].z;
  assign out_data.degenerate     = dg_r;
  assign out_data.last_of_vertex = (kind_r == KIND_BIN);

endmodule

// ===== rtl/torus_vertex_frame_generator_top.sv =====
// Top level of the torus vertex frame generator: registers, front, queue and back.
// Each request names a grid vertex (ring index, side index) and yields five results in
// order: position, texture coordinate, unit tangent, unit normal and binormal, all signed
// Q16.16, with last_of_vertex set on the binormal. A vertex holds the result channel for
// its five results, one per accepted transfer, and that channel sets the sustained vertex
// rate; requests are taken in consecutive cycles until the sixteen-entry angle queue is
// committed. A request passes through the two angle units side by side (each an input
// register, a 27-stage divider, a quadrant register, a 30-stage rotator and an output
// register), then the angle queue, then three arithmetic stages and the output register
// in the back end. Counts of zero act as one and counts above MAX_SUBDIVISIONS act as
// MAX_SUBDIVISIONS. Configuration must be written by the user only while no vertex is in
// flight; the block itself does not enforce this.
module torus_vertex_frame_generator_top #(
  parameter int MAX_SUBDIVISIONS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tvfg_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tvfg_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [tvfg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvfg_pkg::CFG_W-1:0]    cfg_wdata
);
  import tvfg_pkg::*;

  logic [RAD_W-1:0] minor_r;
  logic [RAD_W-1:0] major_r;
  logic [CNT_W-1:0] rings_r;
  logic [CNT_W-1:0] sides_r;
  logic [CNT_W-1:0] rings_eff;
  logic [CNT_W-1:0] sides_eff;

  logic      q_push;
  logic      q_pop;
  job_t      q_wdata;
  job_t      q_rdata;
  q_status_t q_stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minor_r <= 16'd256;
      major_r <= 16'd512;
      rings_r <= 11'd16;
      sides_r <= 11'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MINOR: minor_r <= cfg_wdata;
        CFG_MAJOR: major_r <= cfg_wdata;
        CFG_RINGS: rings_r <= cfg_wdata[CNT_W-1:0];
        CFG_SIDES: sides_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts: zero acts as one, large counts are limited.
  always_comb begin
    if (rings_r == '0) begin
      rings_eff = CNT_W'(1);
    end else if (int'(rings_r) > MAX_SUBDIVISIONS) begin
      rings_eff = CNT_W'(MAX_SUBDIVISIONS);
    end else begin
      rings_eff = rings_r;
    end
    if (sides_r == '0) begin
      sides_eff = CNT_W'(1);
    end else if (int'(sides_r) > MAX_SUBDIVISIONS) begin
      sides_eff = CNT_W'(MAX_SUBDIVISIONS);
    end else begin
      sides_eff = sides_r;
    end
  end

  tvfg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .rings    (rings_eff),
    .sides    (sides_eff),
    .q_pop    (q_pop),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  tvfg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  tvfg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .minor_radius (minor_r),
    .major_radius (major_r),
    .q_stat       (q_stat),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

`ifndef SYNTHESIS
  // The credit scheme must keep the queue from overflowing.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (!q_stat.full || q_pop))
    else $error("angle queue written while full");

  // Results of one vertex come out in kind order.
  a_kind_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.vector_kind != KIND_BIN) |=>
    (out_valid && out_data.vector_kind == $past(out_data.vector_kind) + 3'd1))
    else $error("result kind sequence broken");

  // A degenerate vertex has a zero tangent.
  a_degen_tan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate && out_data.vector_kind == KIND_TAN) |->
    (out_data.comp_x == '0 && out_data.comp_y == '0))
    else $error("degenerate vertex with nonzero tangent");
`endif

endmodule

// ===== test/torus_vertex_frame_generator_top_test.sv =====
// Self-checking testbench of the torus vertex frame generator: random and directed vertices.
module torus_vertex_frame_generator_top_test;
  import tvfg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SUB = 1024;
  localparam longint TIMEOUT_CYCLES = 400000;

  // Arctangent of 2^-k in units of 2^-32 turns.
  localparam longint ATAN_STEP [30] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Testbench copy of the registers.
  logic [15:0] tube_r, ring_r;
  logic [10:0] rings_n, sides_n;

  in_item_t vertex_queue[$];
  out_item_t frame_queue[$];
  int send_gap = 0;
  int recv_gap = 0;
  int errors = 0;
  longint cycles = 0;

  torus_vertex_frame_generator_top i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint round_shr(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic longint used_count(logic [10:0] c);
    if (c == 0) return 1;
    if (c > MAX_SUB) return MAX_SUB;
    return longint'(c);
  endfunction

  // Cosine and sine of idx/count turns in Q16.16, by rotation.
  task automatic turn_sincos(input longint idx, input longint count,
                             output longint c, output longint s);
    longint ph, p32, q, z, x, y, dx, dy, cx, sy;
    ph = ((idx << ANGLE_BITS) / count) & 64'hFFFF;
    p32 = (ph << 16) & 64'hFFFFFFFF;
    q = ((p32 + 64'h20000000) >> 30) & 3;
    z = p32 - (q << 30);
    if (z >= 64'sh80000000) z -= 64'sh100000000;
    x = 652032874;
    y = 0;
    for (int k = 0; k < 30; k++) begin
      dx = shr_floor(y, k);
      dy = shr_floor(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_STEP[k];
      end else begin
        x += dx; y -= dy; z += ATAN_STEP[k];
      end
    end
    cx = clip_unit(round_shr(x, 14));
    sy = clip_unit(round_shr(y, 14));
    case (q)
      0: begin c = cx; s = sy; end
      1: begin c = -sy; s = cx; end
      2: begin c = -cx; s = -sy; end
      default: begin c = sy; s = -cx; end
    endcase
  endtask

  function automatic out_item_t frame_entry(logic [2:0] kind, longint x, longint y,
                                            longint z, logic degen);
    out_item_t o;
    o.vector_kind = kind;
    o.comp_x = x[31:0];
    o.comp_y = y[31:0];
    o.comp_z = z[31:0];
    o.degenerate = degen;
    o.last_of_vertex = (kind == KIND_BIN);
    return o;
  endfunction

  // Work out the five frame vectors of one vertex.
  task automatic predict_frame(input in_item_t v);
    longint rings, sides, r, big, ct, st, cp, sp, dist_val, tx, ty, nx, ny, nz;
    logic degen;
    rings = used_count(rings_n);
    sides = used_count(sides_n);
    r = longint'(tube_r);
    big = longint'(ring_r);
    turn_sincos(longint'(v.ring_index), rings, ct, st);
    turn_sincos(longint'(v.side_index), sides, cp, sp);
    dist_val = big * 256 + round_shr(r * cp, 8);
    degen = (dist_val == 0);
    if (dist_val > 0) begin
      tx = -st; ty = -ct;
    end else if (dist_val < 0) begin
      tx = st; ty = ct;
    end else begin
      tx = 0; ty = 0;
    end
    nx = round_shr(ct * cp, 16);
    ny = round_shr(-st * cp, 16);
    nz = sp;
    frame_queue.push_back(frame_entry(KIND_POS, round_shr(ct * dist_val, 16),
                                      round_shr(-st * dist_val, 16), round_shr(r * sp, 8),
                                      degen));
    frame_queue.push_back(frame_entry(KIND_TEX, (longint'(v.side_index) << 16) / sides,
                                      (longint'(v.ring_index) << 16) / rings, 0, degen));
    frame_queue.push_back(frame_entry(KIND_TAN, tx, ty, 0, degen));
    frame_queue.push_back(frame_entry(KIND_NRM, nx, ny, nz, degen));
    frame_queue.push_back(frame_entry(KIND_BIN, round_shr(-nz * ty, 16),
                                      round_shr(nz * tx, 16),
                                      round_shr(nx * ty - ny * tx, 16), degen));
  endtask

  // Request driver: holds each request until accepted, then waits a random gap.
  always @(posedge clk) begin
    int gap;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_frame(in_data);
        gap = $urandom_range(0, 6);
        if (gap == 0 && vertex_queue.size() > 0) begin
          in_data <= vertex_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
          send_gap <= (gap > 0) ? gap - 1 : 0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (vertex_queue.size() > 0) begin
          in_data <= vertex_queue.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Result monitor and random stall.
  always @(posedge clk) begin
    int gap;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (frame_queue.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, out_data);
          errors++;
        end else begin
          out_item_t exp_item;
          exp_item = frame_queue.pop_front();
          if (exp_item !== out_data) begin
            $display("%0t result mismatch: expected %p actual %p", $time, exp_item, out_data);
            errors++;
          end
        end
        gap = $urandom_range(0, 6);
        recv_gap <= (gap > 0) ? gap - 1 : 0;
        out_stall <= (gap != 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MINOR: tube_r = val;
      CFG_MAJOR: ring_r = val;
      CFG_RINGS: rings_n = val[10:0];
      default: sides_n = val[10:0];
    endcase
  endtask

  task automatic drain();
    while (vertex_queue.size() > 0 || in_valid || frame_queue.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic in_item_t vertex(int i, int j);
    in_item_t v;
    v.ring_index = IDX_W'(i);
    v.side_index = IDX_W'(j);
    return v;
  endfunction

  task automatic random_phase(int n, int limit);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0)
        vertex_queue.push_back(vertex($urandom_range(0, 2047), $urandom_range(0, 2047)));
      else
        vertex_queue.push_back(vertex($urandom_range(0, limit), $urandom_range(0, limit)));
    end
    drain();
  endtask

  initial begin
    tube_r = 256;
    ring_r = 512;
    rings_n = 16;
    sides_n = 16;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed vertices at reset settings: corners, wrap and out-of-range indexes.
    vertex_queue.push_back(vertex(0, 0));
    vertex_queue.push_back(vertex(4, 4));
    vertex_queue.push_back(vertex(8, 8));
    vertex_queue.push_back(vertex(16, 16));
    vertex_queue.push_back(vertex(17, 3));
    vertex_queue.push_back(vertex(1024, 1024));
    vertex_queue.push_back(vertex(2047, 2047));
    vertex_queue.push_back(vertex(1365, 682));
    drain();

    // Degenerate torus: major radius equals minor radius, side half a turn.
    write_reg(CFG_MINOR, 16'd256);
    write_reg(CFG_MAJOR, 16'd256);
    write_reg(CFG_RINGS, 16'd0);
    write_reg(CFG_SIDES, 16'd2);
    vertex_queue.push_back(vertex(0, 1));
    vertex_queue.push_back(vertex(5, 1));
    vertex_queue.push_back(vertex(0, 0));
    drain();

    // Radii at extremes, counts above the limit and at the limit.
    write_reg(CFG_MINOR, 16'hFFFF);
    write_reg(CFG_MAJOR, 16'd0);
    write_reg(CFG_RINGS, 16'h07FF);
    write_reg(CFG_SIDES, 16'd1024);
    vertex_queue.push_back(vertex(0, 512));
    vertex_queue.push_back(vertex(256, 0));
    vertex_queue.push_back(vertex(1023, 768));
    vertex_queue.push_back(vertex(2047, 1024));
    drain();

    write_reg(CFG_MINOR, 16'd0);
    write_reg(CFG_MAJOR, 16'hFFFF);
    write_reg(CFG_RINGS, 16'd1);
    write_reg(CFG_SIDES, 16'd3);
    vertex_queue.push_back(vertex(0, 1));
    vertex_queue.push_back(vertex(1, 2));
    vertex_queue.push_back(vertex(2047, 0));
    drain();

    // Random phases over several settings.
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_MINOR, 16'($urandom_range(0, 65535)));
      write_reg(CFG_MAJOR, (p == 1) ? tube_r : 16'($urandom_range(0, 65535)));
      write_reg(CFG_RINGS, 16'($urandom_range(1, 1100)));
      write_reg(CFG_SIDES, (p == 1) ? 16'd4 : 16'($urandom_range(0, 1100)));
      random_phase(30, (p == 1) ? 8 : 1100);
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
